/* src/assert_macros.svh */
// Assertion macros shared by the dispatcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("property violated");
// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (!(cond))) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

/* src/ptd_pkg.sv */
// Types, constants and codes of the periodic task dispatcher.
package ptd_pkg;

  // Table geometry
  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned MAX_OUT     = 16;
  localparam int unsigned IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned TIDX_W      = 4;
  localparam int unsigned CMP_W       = (CNT_W > TIDX_W) ? CNT_W : TIDX_W;
  localparam int unsigned SCAN_MAX    = (TABLE_DEPTH < MAX_OUT) ? TABLE_DEPTH : MAX_OUT;

  // Field widths
  localparam int unsigned MS_W   = 32;
  localparam int unsigned INTV_W = 42;
  localparam int unsigned TIME_W = 64;

  localparam logic [INTV_W-1:0] US_PER_MS = INTV_W'(1000);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0]  CNT_SCAN  = CNT_W'(SCAN_MAX);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_ENABLE = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_FLUSH
  } state_e;

  // Table port controls from the sequencer
  typedef struct packed {
    logic              wr_intv_en;
    logic              wr_last_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [INTV_W-1:0] wr_intv;
    logic [TIME_W-1:0] wr_last;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
  } tbl_ctrl_t;

endpackage

/* src/periodic_task_dispatcher.sv */
// Periodic task dispatcher top level: sequencer, task state and result register.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------------------------
//   input   | in_valid_i / in_ready_o | func_i task_index_i period_ms_i
//           |                         | enable_flag_i now_us_i
//   output  | out_valid_o/out_ready_i | fired_index_o fired_o last_o status_o
//
// Add, set enable and unused codes pass from the capture registers through S_EXEC
// and S_FLUSH into the output register. Tick: S_EXEC starts a scan of
// min(entries used, 16) entries in S_CHECK, then S_FLUSH loads the final result;
// the used entries pass in turn through the shared compare and table read port.
// A held output register stalls the scan when a further due entry is found and
// holds the final result, which keeps the input closed until it is taken.
// rst_ni clears control state asynchronously; the tables need no clearing pass.
`include "assert_macros.svh"
module periodic_task_dispatcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    func_i,
  input  logic [ptd_pkg::TIDX_W-1:0]    task_index_i,
  input  logic [ptd_pkg::MS_W-1:0]      period_ms_i,
  input  logic                          enable_flag_i,
  input  logic [ptd_pkg::TIME_W-1:0]    now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptd_pkg::TIDX_W-1:0]    fired_index_o,
  output logic                          fired_o,
  output logic                          last_o,
  output logic [1:0]                    status_o
);

  ptd_pkg::state_e state_q, state_d;

  // Captured transaction
  logic [1:0]                    func_q;
  logic [ptd_pkg::TIDX_W-1:0]    tidx_q;
  logic [ptd_pkg::MS_W-1:0]      ms_q;
  logic                          flag_q;
  logic [ptd_pkg::TIME_W-1:0]    now_q;

  // Task state
  logic [ptd_pkg::CNT_W-1:0]       cnt_q;
  logic [ptd_pkg::TABLE_DEPTH-1:0] en_q;

  // Scan and pending result
  logic [ptd_pkg::IDX_W-1:0] scan_q;
  logic [ptd_pkg::CNT_W-1:0] limit_q;
  logic                      pend_valid_q;
  logic [ptd_pkg::IDX_W-1:0] pend_idx_q;
  ptd_pkg::status_e          resp_status_q, resp_status_d;

  // Output register
  logic                       out_valid_q;
  logic [ptd_pkg::TIDX_W-1:0] out_idx_q;
  logic                       out_fired_q;
  logic                       out_last_q;
  ptd_pkg::status_e           out_status_q;

  // Control
  ptd_pkg::tbl_ctrl_t         tbl_ctrl;
  logic [ptd_pkg::INTV_W-1:0] rd_intv;
  logic [ptd_pkg::TIME_W-1:0] rd_last;
  logic                       due;
  logic                       out_free;
  logic                       stall;
  logic                       advance;
  logic                       push;
  logic [ptd_pkg::IDX_W-1:0]  push_idx;
  logic                       push_fired;
  logic                       push_last;
  ptd_pkg::status_e           push_status;
  logic                       add_commit;
  logic                       en_write;
  logic                       pend_load;
  logic                       scan_start;

  logic [ptd_pkg::CMP_W-1:0]  tidx_ext;
  logic [ptd_pkg::CMP_W-1:0]  cnt_ext;
  logic                       idx_ok;
  logic                       full;
  logic [ptd_pkg::CNT_W-1:0]  limit_val;
  logic [ptd_pkg::CNT_W-1:0]  scan_next;
  logic                       scan_done;
  logic [ptd_pkg::INTV_W-1:0] ms_ext;
  logic [ptd_pkg::INTV_W-1:0] intv_us;
  logic [ptd_pkg::CMP_W-1:0]  push_idx_ext;

  // Decode helpers
  assign tidx_ext  = ptd_pkg::CMP_W'(tidx_q);
  assign cnt_ext   = ptd_pkg::CMP_W'(cnt_q);
  assign idx_ok    = tidx_ext < cnt_ext;
  assign full      = cnt_q == ptd_pkg::CNT_FULL;
  assign limit_val = (cnt_q > ptd_pkg::CNT_SCAN) ? ptd_pkg::CNT_SCAN : cnt_q;
  assign scan_next = ptd_pkg::CNT_W'(scan_q) + ptd_pkg::CNT_W'(1);
  assign scan_done = scan_next == limit_q;
  // ms * 1000 as ms * 1024 - ms * 16 - ms * 8
  assign ms_ext    = ptd_pkg::INTV_W'(ms_q);
  assign intv_us   = (ms_ext << 10) - (ms_ext << 4) - (ms_ext << 3);

  // Output slot and scan stall
  assign out_free = !out_valid_q || out_ready_i;
  assign stall    = due && pend_valid_q && !out_free;
  assign advance  = !stall;

  ptd_table u_table (
    .clk_i     (clk_i),
    .ctrl_i    (tbl_ctrl),
    .rd_intv_o (rd_intv),
    .rd_last_o (rd_last)
  );

  ptd_due_unit u_due (
    .now_i      (now_q),
    .last_run_i (rd_last),
    .interval_i (rd_intv),
    .enable_i   (en_q[scan_q]),
    .due_o      (due)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ptd_pkg::S_IDLE: begin
        if (in_valid_i) state_d = ptd_pkg::S_EXEC;
      end
      ptd_pkg::S_EXEC: begin
        if ((func_q == ptd_pkg::FUNC_TICK) && (limit_val != '0)) begin
          state_d = ptd_pkg::S_CHECK;
        end else begin
          state_d = ptd_pkg::S_FLUSH;
        end
      end
      ptd_pkg::S_CHECK: begin
        if (advance && scan_done) state_d = ptd_pkg::S_FLUSH;
      end
      ptd_pkg::S_FLUSH: begin
        if (out_free) state_d = ptd_pkg::S_IDLE;
      end
      default: state_d = ptd_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    tbl_ctrl      = '0;
    push          = 1'b0;
    push_idx      = '0;
    push_fired    = 1'b0;
    push_last     = 1'b0;
    push_status   = ptd_pkg::ST_OK;
    add_commit    = 1'b0;
    en_write      = 1'b0;
    pend_load     = 1'b0;
    scan_start    = 1'b0;
    resp_status_d = resp_status_q;
    unique case (state_q)
      ptd_pkg::S_IDLE: ;
      ptd_pkg::S_EXEC: begin
        resp_status_d = ptd_pkg::ST_OK;
        unique case (func_q)
          ptd_pkg::FUNC_ADD: begin
            if (full) begin
              resp_status_d = ptd_pkg::ST_FULL;
            end else begin
              add_commit          = 1'b1;
              tbl_ctrl.wr_intv_en = 1'b1;
              tbl_ctrl.wr_last_en = 1'b1;
              tbl_ctrl.wr_addr    = cnt_q[ptd_pkg::IDX_W-1:0];
              tbl_ctrl.wr_intv    = intv_us;
              tbl_ctrl.wr_last    = '0;
            end
          end
          ptd_pkg::FUNC_ENABLE: begin
            if (idx_ok) begin
              en_write = 1'b1;
            end else begin
              resp_status_d = ptd_pkg::ST_BAD_INDEX;
            end
          end
          ptd_pkg::FUNC_TICK: begin
            scan_start       = 1'b1;
            tbl_ctrl.rd_en   = 1'b1;
            tbl_ctrl.rd_addr = '0;
          end
          default: ;
        endcase
      end
      ptd_pkg::S_CHECK: begin
        tbl_ctrl.rd_en   = advance && !scan_done;
        tbl_ctrl.rd_addr = scan_next[ptd_pkg::IDX_W-1:0];
        if (due && advance) begin
          tbl_ctrl.wr_last_en = 1'b1;
          tbl_ctrl.wr_addr    = scan_q;
          tbl_ctrl.wr_last    = now_q;
          pend_load           = 1'b1;
          // an earlier due entry leaves as a non-final result
          if (pend_valid_q) begin
            push       = 1'b1;
            push_idx   = pend_idx_q;
            push_fired = 1'b1;
          end
        end
      end
      ptd_pkg::S_FLUSH: begin
        if (out_free) begin
          push        = 1'b1;
          push_idx    = pend_valid_q ? pend_idx_q : '0;
          push_fired  = pend_valid_q;
          push_last   = 1'b1;
          push_status = resp_status_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ptd_pkg::S_IDLE;
      cnt_q         <= '0;
      en_q          <= '0;
      scan_q        <= '0;
      limit_q       <= '0;
      pend_valid_q  <= 1'b0;
      resp_status_q <= ptd_pkg::ST_OK;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      resp_status_q <= resp_status_d;
      if (add_commit) begin
        cnt_q                                <= cnt_q + ptd_pkg::CNT_W'(1);
        en_q[cnt_q[ptd_pkg::IDX_W-1:0]]      <= flag_q;
      end
      if (en_write) begin
        en_q[tidx_ext[ptd_pkg::IDX_W-1:0]] <= flag_q;
      end
      if (scan_start) begin
        scan_q  <= '0;
        limit_q <= limit_val;
      end else if ((state_q == ptd_pkg::S_CHECK) && advance && !scan_done) begin
        scan_q <= scan_next[ptd_pkg::IDX_W-1:0];
      end
      if (pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (push && push_last) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign push_idx_ext = ptd_pkg::CMP_W'(push_idx);

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      tidx_q <= task_index_i;
      ms_q   <= period_ms_i;
      flag_q <= enable_flag_i;
      now_q  <= now_us_i;
    end
    if (pend_load) begin
      pend_idx_q <= scan_q;
    end
    if (push) begin
      out_idx_q    <= push_idx_ext[ptd_pkg::TIDX_W-1:0];
      out_fired_q  <= push_fired;
      out_last_q   <= push_last;
      out_status_q <= push_status;
    end
  end

  assign in_ready_o    = state_q == ptd_pkg::S_IDLE;
  assign out_valid_o   = out_valid_q;
  assign fired_index_o = out_idx_q;
  assign fired_o       = out_fired_q;
  assign last_o        = out_last_q;
  assign status_o      = out_status_q;

  // Checks
  `ASSERT_PROP(a_fired_ok, clk_i, rst_ni, out_valid_o && fired_o |-> status_o == ptd_pkg::ST_OK)
  `ASSERT_PROP(a_mid_fired, clk_i, rst_ni, out_valid_o && !last_o |-> fired_o)
  `ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > ptd_pkg::CNT_FULL)
  `ASSERT_NEVER(a_idle_pend, clk_i, rst_ni, (state_q == ptd_pkg::S_IDLE) && pend_valid_q)

endmodule

/* src/ptd_table.sv */
// Interval and last-run memories, one write and one registered read port each.
module ptd_table (
  input  logic                          clk_i,
  input  ptd_pkg::tbl_ctrl_t            ctrl_i,
  output logic [ptd_pkg::INTV_W-1:0]    rd_intv_o,
  output logic [ptd_pkg::TIME_W-1:0]    rd_last_o
);

  logic [ptd_pkg::INTV_W-1:0] intv_mem [ptd_pkg::TABLE_DEPTH];
  logic [ptd_pkg::TIME_W-1:0] last_mem [ptd_pkg::TABLE_DEPTH];

  // Writes
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_intv_en) begin
      intv_mem[ctrl_i.wr_addr] <= ctrl_i.wr_intv;
    end
    if (ctrl_i.wr_last_en) begin
      last_mem[ctrl_i.wr_addr] <= ctrl_i.wr_last;
    end
  end

  // Registered reads, held while rd_en is low
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_intv_o <= intv_mem[ctrl_i.rd_addr];
      rd_last_o <= last_mem[ctrl_i.rd_addr];
    end
  end

endmodule

/* src/ptd_due_unit.sv */
// Shared elapsed-time subtract and compare used once per scanned entry.
module ptd_due_unit (
  input  logic [ptd_pkg::TIME_W-1:0] now_i,
  input  logic [ptd_pkg::TIME_W-1:0] last_run_i,
  input  logic [ptd_pkg::INTV_W-1:0] interval_i,
  input  logic                       enable_i,
  output logic                       due_o
);

  logic [ptd_pkg::TIME_W-1:0] elapsed;

  // Wrapping 64-bit elapsed time against the interval
  assign elapsed = now_i - last_run_i;
  assign due_o   = enable_i && (elapsed >= ptd_pkg::TIME_W'(interval_i));

endmodule

/* sim/periodic_task_dispatcher_tb.sv */
// Self-checking testbench for the periodic task dispatcher: directed and random dispatch traffic.
module periodic_task_dispatcher_tb;

  // Opcode that the block must treat as a no-op
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 70;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]  func;
    logic [3:0]  task_idx;
    logic [31:0] period_ms;
    logic        enable;
    logic [63:0] now_us;
  } dispatch_cmd_t;

  typedef struct packed {
    logic [3:0]       idx;
    logic             fired;
    logic             last;
    ptd_pkg::status_e status;
  } dispatch_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  func;
  logic [3:0]  task_idx;
  logic [31:0] period_ms;
  logic        enable_flag;
  logic [63:0] now_us;
  logic        out_valid;
  logic        out_ready;
  logic [3:0]  fired_index;
  logic        fired;
  logic        last;
  logic [1:0]  status;

  // Predictor copy of the task table
  logic [63:0] interval_us_tbl [ptd_pkg::TABLE_DEPTH];
  logic [63:0] last_run_tbl [ptd_pkg::TABLE_DEPTH];
  logic [ptd_pkg::TABLE_DEPTH-1:0] task_enabled;
  int unsigned tasks_used;

  dispatch_result_t pending_results[$];
  int unsigned fail_count;
  logic [63:0] tick_time;
  logic tx_burst;
  logic rx_burst;
  int unsigned rx_hold_cycles;

  periodic_task_dispatcher dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .func_i        (func),
    .task_index_i  (task_idx),
    .period_ms_i   (period_ms),
    .enable_flag_i (enable_flag),
    .now_us_i      (now_us),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .fired_index_o (fired_index),
    .fired_o       (fired),
    .last_o        (last),
    .status_o      (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Update the table copy and queue the results one command causes
  task automatic predict_dispatch(input dispatch_cmd_t cmd);
    dispatch_result_t res;
    logic [63:0] elapsed;
    int unsigned scan;
    int unsigned n_fired;
    res = '{idx: 4'd0, fired: 1'b0, last: 1'b1, status: ptd_pkg::ST_OK};
    n_fired = 0;
    case (cmd.func)
      ptd_pkg::FUNC_ADD: begin
        if (tasks_used >= ptd_pkg::TABLE_DEPTH) begin
          res.status = ptd_pkg::ST_FULL;
        end else begin
          interval_us_tbl[tasks_used] = 64'(cmd.period_ms) * 64'(ptd_pkg::US_PER_MS);
          last_run_tbl[tasks_used] = 64'd0;
          task_enabled[tasks_used] = cmd.enable;
          tasks_used++;
        end
      end
      ptd_pkg::FUNC_ENABLE: begin
        if (int'(cmd.task_idx) >= tasks_used) res.status = ptd_pkg::ST_BAD_INDEX;
        else task_enabled[cmd.task_idx] = cmd.enable;
      end
      ptd_pkg::FUNC_TICK: begin
        scan = (tasks_used < ptd_pkg::MAX_OUT) ? tasks_used : ptd_pkg::MAX_OUT;
        for (int unsigned i = 0; i < scan; i++) begin
          elapsed = cmd.now_us - last_run_tbl[i];
          if (task_enabled[i] && elapsed >= interval_us_tbl[i]) begin
            last_run_tbl[i] = cmd.now_us;
            pending_results.push_back('{idx: 4'(i), fired: 1'b1, last: 1'b0,
                                        status: ptd_pkg::ST_OK});
            n_fired++;
          end
        end
        if (n_fired != 0) pending_results[pending_results.size()-1].last = 1'b1;
      end
      default: ;
    endcase
    if (n_fired == 0) pending_results.push_back(res);
  endtask

  function automatic dispatch_cmd_t random_cmd();
    dispatch_cmd_t cmd;
    cmd.func        = 2'($urandom_range(0, 3));
    cmd.task_idx    = 4'($urandom);
    cmd.period_ms   = $urandom;
    cmd.enable      = 1'($urandom);
    cmd.now_us      = {$urandom, $urandom};
    return cmd;
  endfunction

  function automatic dispatch_cmd_t make_add(input logic [31:0] ms, input logic en);
    dispatch_cmd_t cmd;
    cmd = random_cmd();
    cmd.func = ptd_pkg::FUNC_ADD;
    cmd.period_ms = ms;
    cmd.enable = en;
    return cmd;
  endfunction

  function automatic dispatch_cmd_t make_enable(input logic [3:0] idx, input logic en);
    dispatch_cmd_t cmd;
    cmd = random_cmd();
    cmd.func = ptd_pkg::FUNC_ENABLE;
    cmd.task_idx = idx;
    cmd.enable = en;
    return cmd;
  endfunction

  function automatic dispatch_cmd_t make_tick(input logic [63:0] now);
    dispatch_cmd_t cmd;
    cmd = random_cmd();
    cmd.func = ptd_pkg::FUNC_TICK;
    cmd.now_us = now;
    return cmd;
  endfunction

  // Offer one command transaction; called and returns at a falling edge
  task automatic send_cmd(input dispatch_cmd_t cmd);
    int unsigned gap;
    gap = tx_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func        = cmd.func;
    task_idx    = cmd.task_idx;
    period_ms   = cmd.period_ms;
    enable_flag = cmd.enable;
    now_us      = cmd.now_us;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_dispatch(cmd);
    @(negedge clk);
  endtask

  // Result sink: random stalls, optional long hold-off, compare against oldest expectation
  initial begin : result_sink
    dispatch_result_t got;
    dispatch_result_t want;
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (rx_hold_cycles != 0) begin
        out_ready = 1'b0;
        repeat (rx_hold_cycles) @(negedge clk);
        rx_hold_cycles = 0;
      end
      stall = rx_burst ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got.idx    = fired_index;
      got.fired  = fired;
      got.last   = last;
      got.status = ptd_pkg::status_e'(status);
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: idx=%0d fired=%0b last=%0b status=%0d",
                   got.idx, got.fired, got.last, got.status);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch (idx fired last status): exp %0d %0b %0b %0d, got %0d %0b %0b %0d",
                     want.idx, want.fired, want.last, want.status,
                     got.idx, got.fired, got.last, got.status);
        end
      end
      @(negedge clk);
    end
  end

  // Empty table: nothing due, bad indexes, unused opcode
  task automatic test_empty_table();
    dispatch_cmd_t cmd;
    send_cmd(make_tick(64'd0));
    send_cmd(make_enable(4'd0, 1'b1));
    send_cmd(make_enable(4'd15, 1'b1));
    cmd = random_cmd();
    cmd.func = FUNC_UNUSED;
    send_cmd(cmd);
  endtask

  // Interval extremes, disabled entries, multi-fire ticks and time wraparound
  task automatic test_add_and_fire();
    dispatch_cmd_t cmd;
    send_cmd(make_add(32'd0, 1'b1));
    send_cmd(make_add(32'd1, 1'b0));
    send_cmd(make_add(32'hFFFF_FFFF, 1'b1));
    send_cmd(make_tick(64'd0));
    send_cmd(make_tick(64'd1000));
    send_cmd(make_enable(4'd1, 1'b1));
    send_cmd(make_tick(64'd2000));
    send_cmd(make_tick(64'd2999));
    send_cmd(make_tick(64'hFFFF_FFFF_FFFF_FFFF));
    send_cmd(make_tick(64'd5));
    send_cmd(make_enable(4'd2, 1'b0));
    send_cmd(make_enable(4'd3, 1'b1));
    cmd = random_cmd();
    cmd.func = FUNC_UNUSED;
    send_cmd(cmd);
    tick_time = 64'd10_000;
  endtask

  // Mostly ticks on an advancing clock, mixed with adds, enables and stray opcodes
  task automatic test_random_traffic();
    dispatch_cmd_t cmd;
    int unsigned sel;
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 15 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        cmd = make_add(($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 20),
                       1'($urandom));
      end else if (sel < 40) begin
        cmd = make_enable(4'($urandom), 1'($urandom));
        if (tasks_used != 0 && $urandom_range(0, 3) != 0)
          cmd.task_idx = 4'($urandom_range(0, tasks_used - 1));
      end else if (sel < 95) begin
        // occasional jump anywhere, which may move time backwards and wrap
        if ($urandom_range(0, 9) == 0) tick_time = {$urandom, $urandom};
        else tick_time += 64'($urandom_range(0, 25000));
        cmd = make_tick(tick_time);
      end else begin
        cmd = random_cmd();
        cmd.func = FUNC_UNUSED;
      end
      send_cmd(cmd);
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  // Long receiver hold-off while ticks keep coming back to back
  task automatic test_output_backpressure();
    send_cmd(make_add(32'd0, 1'b1));
    tx_burst = 1'b1;
    rx_hold_cycles = 300;
    for (int unsigned n = 0; n < 24; n++) begin
      tick_time += 64'd1000;
      send_cmd(make_tick(tick_time));
    end
    tx_burst = 1'b0;
  endtask

  // Fill the table, overflow it, then scan every slot
  task automatic test_table_full();
    while (tasks_used < ptd_pkg::TABLE_DEPTH)
      send_cmd(make_add(32'($urandom_range(0, 3)), 1'b1));
    send_cmd(make_add(32'd1, 1'b1));
    send_cmd(make_add(32'hFFFF_FFFF, 1'b0));
    send_cmd(make_enable(4'd15, 1'b0));
    send_cmd(make_enable(4'd15, 1'b1));
    for (int unsigned i = 0; i < ptd_pkg::TABLE_DEPTH; i++) task_enabled[i] = task_enabled[i];
    send_cmd(make_enable(4'd0, 1'b1));
    tick_time += 64'd5_000_000;
    send_cmd(make_tick(tick_time));
    tick_time += 64'd5_000_000;
    send_cmd(make_tick(tick_time));
  endtask

  initial begin : stimulus
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    func           = ptd_pkg::FUNC_ADD;
    task_idx       = 4'd0;
    period_ms      = 32'd0;
    enable_flag    = 1'b0;
    now_us         = 64'd0;
    task_enabled   = '0;
    tasks_used     = 0;
    fail_count     = 0;
    tick_time      = 64'd0;
    tx_burst       = 1'b0;
    rx_burst       = 1'b0;
    rx_hold_cycles = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_table();
    test_add_and_fire();
    test_random_traffic();
    test_output_backpressure();
    test_table_full();
    in_valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/ptd_pkg.sv
src/ptd_table.sv
src/ptd_due_unit.sv
src/periodic_task_dispatcher.sv
sim/periodic_task_dispatcher_tb.sv
